>>> hdl/blsr_pkg.sv
// Shared types and constants of the styled line rasterizer.
package blsr_pkg;

	localparam int STYLE_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [STYLE_BITS-1:0] STYLE_SOLID = 3'd1;
	localparam logic [STYLE_BITS-1:0] STYLE_DOTTED = 3'd2;
	localparam logic [STYLE_BITS-1:0] STYLE_DASHED = 3'd3;
	localparam logic [STYLE_BITS-1:0] STYLE_THICK = 3'd4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Register index, taken from paddr[2].
	localparam logic REG_LINE_STYLE = 1'b0;

	localparam int PHASE_BITS = 5;
	localparam logic [PHASE_BITS-1:0] PHASE_LAST = 5'd19;
	localparam logic [PHASE_BITS-1:0] DASH_PERIOD = 5'd10;
	localparam logic [PHASE_BITS-1:0] DASH_ON = 5'd6;

	typedef struct packed {
		logic done;
		logic thick;
	} step_flags_t;

endpackage

>>> hdl/bresenham_line_styled_rasterizer_core.sv
// Top level of the styled Bresenham line rasterizer: config port, front, queue and back.
//
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   opcode, start_x, start_y, end_x, end_y
// out      output     out_valid/out_stall pixel_x, pixel_y, last_of_step, line_done
// apb      input      psel/penable/pready line_style at byte address 0
//
// A load or tick beat is taken every cycle while the four-entry step queue has room.
// Each drawn tick gives one pixel beat, or five in thick style; the single output register
// passes one pixel a cycle while out_stall is low, so thick lines accept ticks more slowly.
// A drawn tick's record is registered in the queue first; out_valid rises once the back end
// loads it from the queue head into the output register, which an output stall can delay.
// Reset idles the line and sets the style to solid; no clearing pass is needed.
// Output stalls back up through the queue to in_stall only once the queue fills.
module bresenham_line_styled_rasterizer_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  opcode,
	input  logic [COORD_BITS-1:0]                 start_x,
	input  logic [COORD_BITS-1:0]                 start_y,
	input  logic [COORD_BITS-1:0]                 end_x,
	input  logic [COORD_BITS-1:0]                 end_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [COORD_BITS:0]                   pixel_x,
	output logic [COORD_BITS:0]                   pixel_y,
	output logic                                  last_of_step,
	output logic                                  line_done,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [blsr_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [blsr_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [blsr_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                  pready
);

	localparam int QW = 2 * COORD_BITS + 2;

	logic [blsr_pkg::STYLE_BITS-1:0] line_style_q;
	logic                            q_full, q_empty, push, pop;
	logic [COORD_BITS-1:0]           rec_x, rec_y, head_x, head_y;
	blsr_pkg::step_flags_t           rec_flags, head_flags;
	logic [QW-1:0]                   head_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == blsr_pkg::REG_LINE_STYLE) ?
		{{(blsr_pkg::APB_DATA_BITS - blsr_pkg::STYLE_BITS){1'b0}}, line_style_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_style_q <= blsr_pkg::STYLE_SOLID;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == blsr_pkg::REG_LINE_STYLE)) begin
			line_style_q <= pwdata[blsr_pkg::STYLE_BITS-1:0];
		end
	end

	blsr_front #(
		.CW(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.line_style(line_style_q),
		.q_full    (q_full),
		.push      (push),
		.rec_x     (rec_x),
		.rec_y     (rec_y),
		.rec_flags (rec_flags)
	);

	blsr_queue #(
		.WIDTH(QW),
		.DEPTH(blsr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({rec_flags, rec_y, rec_x}),
		.pop      (pop),
		.head_data(head_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	assign head_x = head_data[COORD_BITS-1:0];
	assign head_y = head_data[2*COORD_BITS-1:COORD_BITS];
	assign head_flags = head_data[QW-1:2*COORD_BITS];

	blsr_back #(
		.CW(COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_x      (head_x),
		.head_y      (head_y),
		.head_flags  (head_flags),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.last_of_step(last_of_step),
		.line_done   (line_done)
	);

endmodule

>>> hdl/blsr_queue.sv
// Small register queue that carries step records from the front to the back.
module blsr_queue #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(DEPTH - 1)) r = '0;
		else r = p + PW'(1);
		return r;
	endfunction

	assign full = (count_q == CNTW'(DEPTH));
	assign empty = (count_q == '0);
	assign head_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNTW'(1);
			else if (pop && !push) count_q <= count_q - CNTW'(1);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue count out of range");

endmodule

>>> hdl/blsr_front.sv
// Front end: takes load and tick beats, runs the Bresenham state and emits step records.
module blsr_front #(
	parameter int CW = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             opcode,
	input  logic [CW-1:0]                    start_x,
	input  logic [CW-1:0]                    start_y,
	input  logic [CW-1:0]                    end_x,
	input  logic [CW-1:0]                    end_y,
	input  logic [blsr_pkg::STYLE_BITS-1:0]  line_style,
	input  logic                             q_full,
	output logic                             push,
	output logic [CW-1:0]                    rec_x,
	output logic [CW-1:0]                    rec_y,
	output blsr_pkg::step_flags_t            rec_flags
);

	localparam int DW = CW + 3;
	localparam int SW = CW + 1;

	logic                             active_q;
	logic [CW-1:0]                    cur_x_q;
	logic [CW-1:0]                    cur_y_q;
	logic [CW-1:0]                    abs_dx_q;
	logic [CW-1:0]                    abs_dy_q;
	logic                             dir_x_neg_q;
	logic                             dir_y_neg_q;
	logic                             x_major_q;
	logic [DW-1:0]                    decision_q;
	logic [SW-1:0]                    steps_left_q;
	logic [blsr_pkg::PHASE_BITS-1:0]  phase_q;

	logic                             accept;
	logic [CW:0]                      dx, dy, ndx, ndy;
	logic [CW-1:0]                    ld_abs_dx, ld_abs_dy, ld_major, ld_minor;
	logic                             ld_x_major;
	logic [DW-1:0]                    two_dx, two_dy;
	logic [DW-1:0]                    dec_next;
	logic [CW-1:0]                    x_next, y_next, sx, sy;
	logic [SW-1:0]                    steps_next;
	logic [blsr_pkg::PHASE_BITS-1:0]  phase_mod10;
	logic                             draw;
	logic                             tick_step;

	assign accept = in_valid && !in_stall;
	assign in_stall = q_full;
	assign tick_step = accept && (opcode == blsr_pkg::OP_TICK) && active_q;

	// Load setup: deltas, directions, major axis.
	always_comb begin
		dx = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
		dy = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
		ndx = -dx;
		ndy = -dy;
		ld_abs_dx = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
		ld_abs_dy = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
		ld_x_major = (ld_abs_dx >= ld_abs_dy);
		ld_major = ld_x_major ? ld_abs_dx : ld_abs_dy;
		ld_minor = ld_x_major ? ld_abs_dy : ld_abs_dx;
	end

	// One Bresenham step.
	always_comb begin
		two_dx = {2'b00, abs_dx_q, 1'b0};
		two_dy = {2'b00, abs_dy_q, 1'b0};
		sx = dir_x_neg_q ? '1 : CW'(1);
		sy = dir_y_neg_q ? '1 : CW'(1);
		x_next = cur_x_q;
		y_next = cur_y_q;
		if (x_major_q) begin
			x_next = cur_x_q + sx;
			if (decision_q[DW-1]) begin
				dec_next = decision_q + two_dy;
			end else begin
				y_next = cur_y_q + sy;
				dec_next = decision_q + two_dy - two_dx;
			end
		end else begin
			y_next = cur_y_q + sy;
			if (decision_q[DW-1]) begin
				dec_next = decision_q + two_dx;
			end else begin
				x_next = cur_x_q + sx;
				dec_next = decision_q + two_dx - two_dy;
			end
		end
		steps_next = (steps_left_q != '0) ? steps_left_q - SW'(1) : steps_left_q;
	end

	always_comb begin
		phase_mod10 = (phase_q >= blsr_pkg::DASH_PERIOD) ?
			phase_q - blsr_pkg::DASH_PERIOD : phase_q;
		case (line_style)
			blsr_pkg::STYLE_SOLID:  draw = 1'b1;
			blsr_pkg::STYLE_DOTTED: draw = (phase_q[1:0] == 2'b00);
			blsr_pkg::STYLE_DASHED: draw = (phase_mod10 < blsr_pkg::DASH_ON);
			blsr_pkg::STYLE_THICK:  draw = 1'b1;
			default:                draw = 1'b0;
		endcase
	end

	assign push = tick_step && draw;
	assign rec_x = cur_x_q;
	assign rec_y = cur_y_q;
	assign rec_flags.done = (steps_next == '0);
	assign rec_flags.thick = (line_style == blsr_pkg::STYLE_THICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			abs_dx_q <= '0;
			abs_dy_q <= '0;
			dir_x_neg_q <= 1'b0;
			dir_y_neg_q <= 1'b0;
			x_major_q <= 1'b0;
			decision_q <= '0;
			steps_left_q <= '0;
			phase_q <= '0;
		end else if (accept && (opcode == blsr_pkg::OP_LOAD)) begin
			active_q <= 1'b1;
			cur_x_q <= start_x;
			cur_y_q <= start_y;
			abs_dx_q <= ld_abs_dx;
			abs_dy_q <= ld_abs_dy;
			dir_x_neg_q <= dx[CW];
			dir_y_neg_q <= dy[CW];
			x_major_q <= ld_x_major;
			decision_q <= {2'b00, ld_minor, 1'b0} - {3'b000, ld_major};
			steps_left_q <= {1'b0, ld_major} + SW'(1);
			phase_q <= '0;
		end else if (tick_step) begin
			cur_x_q <= x_next;
			cur_y_q <= y_next;
			decision_q <= dec_next;
			steps_left_q <= steps_next;
			phase_q <= (phase_q == blsr_pkg::PHASE_LAST) ? '0 :
				phase_q + blsr_pkg::PHASE_BITS'(1);
			if (steps_next == '0) active_q <= 1'b0;
		end
	end

	a_idle_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> !push)
		else $error("step record pushed while no line is active");

endmodule

>>> hdl/blsr_back.sv
// Back end: expands each step record into one or five pixel beats on the output register.
module blsr_back #(
	parameter int CW = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  logic [CW-1:0]          head_x,
	input  logic [CW-1:0]          head_y,
	input  blsr_pkg::step_flags_t  head_flags,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CW:0]            pixel_x,
	output logic [CW:0]            pixel_y,
	output logic                   last_of_step,
	output logic                   line_done
);

	typedef enum logic [2:0] {
		NB_CENTER,
		NB_XP,
		NB_XN,
		NB_YP,
		NB_YN
	} nbr_t;

	nbr_t        sub_q;
	nbr_t        sub_next;
	logic        out_valid_q;
	logic [CW:0] pixel_x_q, pixel_y_q;
	logic        last_q, done_q;
	logic [CW:0] hx, hy, nx, ny;
	logic        last;
	logic        load_out;

	assign hx = {head_x[CW-1], head_x};
	assign hy = {head_y[CW-1], head_y};

	always_comb begin
		nx = hx;
		ny = hy;
		sub_next = NB_CENTER;
		case (sub_q)
			NB_CENTER: sub_next = NB_XP;
			NB_XP: begin
				nx = hx + (CW+1)'(1);
				sub_next = NB_XN;
			end
			NB_XN: begin
				nx = hx - (CW+1)'(1);
				sub_next = NB_YP;
			end
			NB_YP: begin
				ny = hy + (CW+1)'(1);
				sub_next = NB_YN;
			end
			NB_YN: begin
				ny = hy - (CW+1)'(1);
				sub_next = NB_CENTER;
			end
			default: sub_next = NB_CENTER;
		endcase
	end

	assign last = !head_flags.thick || (sub_q == NB_YN);
	assign load_out = !q_empty && (!out_valid_q || !out_stall);
	assign pop = load_out && last;

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_x_q <= nx;
			pixel_y_q <= ny;
			last_q <= last;
			done_q <= head_flags.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= NB_CENTER;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				sub_q <= last ? NB_CENTER : sub_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;
	assign last_of_step = last_q;
	assign line_done = done_q;

	a_empty_at_center: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> sub_q == NB_CENTER)
		else $error("pixel index left mid-record with an empty queue");
	a_thin_at_center: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && !head_flags.thick) |-> sub_q == NB_CENTER)
		else $error("neighbor index on a single-pixel record");

endmodule
